FILE: rtl/dpfa_pkg.sv
// Shared types and constants for the dipole pair force accumulator.
`timescale 1ns / 1ps
package dpfa_pkg;

	localparam int UNIT_BITS = 30;
	localparam int MUL_STEPS = 64;
	localparam int DIV_STEPS = 64;
	localparam int ROOT_STEPS = 32;
	localparam int CNT_W = 7;

	localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ROOT_BIT_INIT = 64'h4000_0000_0000_0000;
	localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;
	localparam logic [63:0] FIVE = 64'd5;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_UNIT,
		SH_FRAC
	} alu_sh_t;

	typedef struct packed {
		alu_op_t     op;
		alu_sh_t     sh;
		logic [63:0] a;
		logic [63:0] b;
		logic [31:0] d;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic        clip;
		logic [63:0] value;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_UNIT,
		ST_DOT,
		ST_WEIGHT,
		ST_TERM,
		ST_SCALE,
		ST_ACCUM,
		ST_FINISH
	} seq_state_t;

endpackage

FILE: rtl/dpfa_alu.sv
// Shared iterative unit: shift-add multiply, restoring divide, digit square root.
`timescale 1ns / 1ps
module dpfa_alu #(
	parameter int FRAC_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  dpfa_pkg::alu_req_t req,
	output dpfa_pkg::alu_rsp_t rsp
);
	import dpfa_pkg::*;

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	alu_op_t            op_q;
	alu_sh_t            sh_q;
	logic               neg_q;
	logic               ovf_q;
	logic [127:0]       prod_q;
	logic [63:0]        opa_q;
	logic [31:0]        rem_q;
	logic [63:0]        root_q;
	logic [63:0]        bit_q;
	logic               done_q;
	logic               clip_q;
	logic [63:0]        value_q;

	logic [63:0]  mag_a;
	logic [63:0]  mag_b;
	logic [127:0] num;
	logic [64:0]  mul_sum;
	logic [32:0]  div_trial;
	logic         div_ge;
	logic [32:0]  div_diff;
	logic [63:0]  root_try;
	logic [127:0] prod_sh;
	logic         fin_sat;
	logic [63:0]  fin_mag;
	logic [63:0]  fin_value;
	logic         fin_clip;

	// Operand magnitudes and shifted dividend
	always_comb begin
		mag_a = req.a[63] ? (64'd0 - req.a) : req.a;
		mag_b = req.b[63] ? (64'd0 - req.b) : req.b;
		case (req.sh)
			SH_UNIT: num = {64'd0, mag_a} << UNIT_BITS;
			SH_FRAC: num = {64'd0, mag_a} << FRAC_BITS;
			default: num = {64'd0, mag_a};
		endcase
	end

	// One step of each iteration
	always_comb begin
		mul_sum = {1'b0, prod_q[127:64]} + (prod_q[0] ? {1'b0, opa_q} : 65'd0);
		div_trial = {rem_q, prod_q[63]};
		div_ge = div_trial >= {1'b0, opa_q[31:0]};
		div_diff = div_trial - {1'b0, opa_q[31:0]};
		root_try = root_q + bit_q;
	end

	// Final scaling, saturation and sign
	always_comb begin
		case (sh_q)
			SH_UNIT: prod_sh = prod_q >> UNIT_BITS;
			SH_FRAC: prod_sh = prod_q >> FRAC_BITS;
			default: prod_sh = prod_q;
		endcase
		fin_sat = 1'b0;
		fin_mag = 64'd0;
		case (op_q)
			ALU_MUL: begin
				fin_sat = |prod_sh[127:63];
				fin_mag = fin_sat ? MAG_MAX : prod_sh[63:0];
			end
			ALU_DIV: begin
				fin_sat = ovf_q | prod_q[63];
				fin_mag = fin_sat ? MAG_MAX : prod_q[63:0];
			end
			default: begin
				fin_sat = 1'b0;
				fin_mag = root_q;
			end
		endcase
		fin_clip = fin_sat;
		fin_value = neg_q ? (64'd0 - fin_mag) : fin_mag;
	end

	// Control: load, count down, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				case (req.op)
					ALU_MUL: cnt_q <= CNT_W'(MUL_STEPS);
					ALU_DIV: cnt_q <= (num[127:64] >= {32'd0, req.d}) ? '0 : CNT_W'(DIV_STEPS);
					default: cnt_q <= CNT_W'(ROOT_STEPS);
				endcase
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= req.op;
			sh_q <= req.sh;
			ovf_q <= 1'b0;
			case (req.op)
				ALU_MUL: begin
					prod_q <= {64'd0, mag_b};
					opa_q <= mag_a;
					neg_q <= req.a[63] ^ req.b[63];
				end
				ALU_DIV: begin
					prod_q <= {64'd0, num[63:0]};
					rem_q <= num[95:64];
					opa_q <= {32'd0, req.d};
					neg_q <= req.a[63];
					ovf_q <= num[127:64] >= {32'd0, req.d};
				end
				default: begin
					prod_q <= {64'd0, req.a};
					root_q <= 64'd0;
					bit_q <= ROOT_BIT_INIT;
					neg_q <= 1'b0;
				end
			endcase
		end else if (busy_q && cnt_q != '0) begin
			case (op_q)
				ALU_MUL: prod_q <= {mul_sum, prod_q[63:1]};
				ALU_DIV: begin
					rem_q <= div_ge ? div_diff[31:0] : div_trial[31:0];
					prod_q[63:0] <= {prod_q[62:0], div_ge};
				end
				default: begin
					if (prod_q[63:0] >= root_try) begin
						prod_q[63:0] <= prod_q[63:0] - root_try;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			endcase
		end
		if (busy_q && cnt_q == '0) begin
			value_q <= fin_value;
			clip_q <= fin_clip;
		end
	end

	assign rsp.done = done_q;
	assign rsp.clip = clip_q;
	assign rsp.value = value_q;

endmodule

FILE: rtl/dipole_pair_force_accumulator_top.sv
// Top level: pair sequencer, accumulators and result register around the shared unit.
//
//   channel  | handshake              | payload
//   input    | in_valid / in_stall    | sep_*, radius_sum, moment_i_*, moment_j_*, last_neighbour
//   output   | out_valid / out_stall  | force_*, zero_distance_seen, saturated
//   config   | cfg_valid / cfg_ready  | cfg_data (force_coefficient)
//
// A pair runs 41 multiplies and divides plus a square root, all through the one shared unit.
// A pair at zero distance runs three squares only.
// in_stall is high from acceptance until the pair is done; a last pair waits while the
// previous result word is still held in the output register.
// Reset clears sums, flags, coefficient and the output valid.
`timescale 1ns / 1ps
module dipole_pair_force_accumulator_top #(
	parameter int FRAC_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] sep_x,
	input  logic signed [31:0] sep_y,
	input  logic signed [31:0] sep_z,
	input  logic [30:0]        radius_sum,
	input  logic signed [31:0] moment_i_x,
	input  logic signed [31:0] moment_i_y,
	input  logic signed [31:0] moment_i_z,
	input  logic signed [31:0] moment_j_x,
	input  logic signed [31:0] moment_j_y,
	input  logic signed [31:0] moment_j_z,
	input  logic               last_neighbour,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] force_x,
	output logic signed [47:0] force_y,
	output logic signed [47:0] force_z,
	output logic               zero_distance_seen,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);
	import dpfa_pkg::*;

	seq_state_t state_q, state_d;
	logic [1:0] axis_q;
	logic [1:0] sub_q;
	logic       pend_q;

	logic [31:0]        coef_q;
	logic signed [31:0] sep_q [3];
	logic signed [31:0] mi_q [3];
	logic signed [31:0] mj_q [3];
	logic signed [31:0] u_q [3];
	logic [30:0]        rsum_q;
	logic               last_q;
	logic [63:0]        r2_q;
	logic [31:0]        r_q;
	logic signed [63:0] mir_q, mjr_q, mumu_q, w_q, t_q;
	logic signed [47:0] sum_q [3];
	logic               zero_q, clip_q;

	logic               out_valid_q;
	logic signed [47:0] force_x_q, force_y_q, force_z_q;
	logic               zero_out_q, sat_out_q;

	alu_req_t  req;
	alu_rsp_t  rsp;
	logic      alu_start;
	logic      accept;
	logic      fin_go;
	logic [63:0] r2_next;

	logic signed [63:0] add_a, add_b;
	logic               add_sub;
	logic signed [64:0] add_raw;
	logic signed [63:0] add_res;
	logic               add_clip;
	logic signed [65:0] acc_raw;
	logic signed [47:0] acc_res;
	logic               acc_clip;

	dpfa_alu #(
		.FRAC_BITS(FRAC_BITS)
	) u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.start(alu_start),
		.req(req),
		.rsp(rsp)
	);

	assign accept = in_valid && !in_stall;
	assign fin_go = (state_q == ST_FINISH) && (!last_q || !out_valid_q || !out_stall);
	assign r2_next = r2_q + rsp.value;
	assign cfg_ready = 1'b1;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SQUARE;
			ST_SQUARE: begin
				if (rsp.done && axis_q == 2'd2) state_d = (r2_next == 64'd0) ? ST_FINISH : ST_ROOT;
			end
			ST_ROOT: if (rsp.done) state_d = ST_UNIT;
			ST_UNIT: if (rsp.done && axis_q == 2'd2) state_d = ST_DOT;
			ST_DOT: if (rsp.done && axis_q == 2'd2 && sub_q == 2'd2) state_d = ST_WEIGHT;
			ST_WEIGHT: if (rsp.done && sub_q == 2'd1) state_d = ST_TERM;
			ST_TERM: if (rsp.done && sub_q == 2'd3) state_d = ST_SCALE;
			ST_SCALE: if (rsp.done && sub_q == 2'd3) state_d = ST_ACCUM;
			ST_ACCUM: state_d = (axis_q == 2'd2) ? ST_FINISH : ST_TERM;
			ST_FINISH: if (fin_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: issue strobe, operand select, input stall
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		alu_start = 1'b0;
		req.op = ALU_MUL;
		req.sh = SH_NONE;
		req.a = 64'd0;
		req.b = 64'd0;
		req.d = r_q;
		case (state_q)
			ST_SQUARE: begin
				alu_start = !pend_q;
				req.a = 64'(sep_q[axis_q]);
				req.b = 64'(sep_q[axis_q]);
			end
			ST_ROOT: begin
				alu_start = !pend_q;
				req.op = ALU_SQRT;
				req.a = r2_q;
			end
			ST_UNIT: begin
				alu_start = !pend_q;
				req.op = ALU_DIV;
				req.sh = SH_UNIT;
				req.a = 64'(sep_q[axis_q]);
			end
			ST_DOT: begin
				alu_start = !pend_q;
				case (sub_q)
					2'd0: begin
						req.sh = SH_UNIT;
						req.a = 64'(mi_q[axis_q]);
						req.b = 64'(u_q[axis_q]);
					end
					2'd1: begin
						req.sh = SH_UNIT;
						req.a = 64'(mj_q[axis_q]);
						req.b = 64'(u_q[axis_q]);
					end
					default: begin
						req.sh = SH_FRAC;
						req.a = 64'(mi_q[axis_q]);
						req.b = 64'(mj_q[axis_q]);
					end
				endcase
			end
			ST_WEIGHT: begin
				alu_start = !pend_q;
				if (sub_q == 2'd0) begin
					req.sh = SH_FRAC;
					req.a = mir_q;
					req.b = mjr_q;
				end else begin
					req.a = t_q;
					req.b = FIVE;
				end
			end
			ST_TERM: begin
				alu_start = !pend_q;
				case (sub_q)
					2'd0: begin
						req.sh = SH_FRAC;
						req.a = mir_q;
						req.b = 64'(mj_q[axis_q]);
					end
					2'd1: begin
						req.sh = SH_FRAC;
						req.a = mjr_q;
						req.b = 64'(mi_q[axis_q]);
					end
					2'd2: begin
						req.sh = SH_UNIT;
						req.a = w_q;
						req.b = 64'(u_q[axis_q]);
					end
					default: begin
						req.sh = SH_FRAC;
						req.a = t_q;
						req.b = {32'd0, coef_q};
					end
				endcase
			end
			ST_SCALE: begin
				alu_start = !pend_q;
				req.op = ALU_DIV;
				req.sh = SH_FRAC;
				req.a = t_q;
			end
			default: alu_start = 1'b0;
		endcase
	end

	// Shared saturating add and subtract
	always_comb begin
		add_a = t_q;
		add_b = rsp.value;
		add_sub = 1'b0;
		case (state_q)
			ST_DOT: begin
				case (sub_q)
					2'd0: add_a = mir_q;
					2'd1: add_a = mjr_q;
					default: add_a = mumu_q;
				endcase
			end
			ST_WEIGHT: begin
				add_a = mumu_q;
				add_sub = 1'b1;
			end
			default: add_a = t_q;
		endcase
		add_raw = add_sub ? ({add_a[63], add_a} - {add_b[63], add_b})
			: ({add_a[63], add_a} + {add_b[63], add_b});
		add_clip = add_raw[64] != add_raw[63];
		if (add_clip) begin
			add_res = add_raw[64] ? VAL_MIN : MAG_MAX;
		end else begin
			add_res = add_raw[63:0];
		end
	end

	// Accumulator clamp to the sum range
	always_comb begin
		acc_raw = 66'(sum_q[axis_q]) + 66'(t_q);
		acc_clip = 1'b1;
		if (acc_raw > 66'(SUM_MAX)) begin
			acc_res = SUM_MAX;
		end else if (acc_raw < 66'(SUM_MIN)) begin
			acc_res = SUM_MIN;
		end else begin
			acc_res = acc_raw[47:0];
			acc_clip = 1'b0;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= 2'd0;
			sub_q <= 2'd0;
			pend_q <= 1'b0;
			coef_q <= 32'd0;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
			zero_q <= 1'b0;
			clip_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) coef_q <= cfg_data;

			// track the outstanding unit request
			if (alu_start) begin
				pend_q <= 1'b1;
			end else if (rsp.done) begin
				pend_q <= 1'b0;
			end
			if (rsp.done) clip_q <= clip_q | rsp.clip;

			// advance axis and step counters
			case (state_q)
				ST_IDLE: begin
					axis_q <= 2'd0;
					sub_q <= 2'd0;
				end
				ST_SQUARE, ST_UNIT: begin
					if (rsp.done) axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
				end
				default: begin
				end
			endcase

			case (state_q)
				ST_DOT: begin
					if (rsp.done) begin
						clip_q <= clip_q | rsp.clip | add_clip;
						if (sub_q == 2'd2) begin
							sub_q <= 2'd0;
							axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
						end else begin
							sub_q <= sub_q + 2'd1;
						end
					end
				end
				ST_WEIGHT: begin
					if (rsp.done) begin
						sub_q <= (sub_q == 2'd1) ? 2'd0 : sub_q + 2'd1;
						if (sub_q == 2'd1) clip_q <= clip_q | rsp.clip | add_clip;
					end
				end
				ST_TERM: begin
					if (rsp.done) begin
						sub_q <= sub_q + 2'd1;
						if (sub_q == 2'd1 || sub_q == 2'd2) begin
							clip_q <= clip_q | rsp.clip | add_clip;
						end
					end
				end
				ST_SCALE: begin
					if (rsp.done) sub_q <= sub_q + 2'd1;
				end
				ST_ACCUM: begin
					sum_q[axis_q] <= acc_res;
					clip_q <= clip_q | acc_clip;
					axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
				end
				ST_SQUARE: begin
					if (rsp.done && axis_q == 2'd2 && r2_next == 64'd0) zero_q <= 1'b1;
				end
				default: begin
				end
			endcase

			// hand the result word to the output register, then clear the sums
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (fin_go && last_q) begin
				out_valid_q <= 1'b1;
				sum_q[0] <= '0;
				sum_q[1] <= '0;
				sum_q[2] <= '0;
				zero_q <= 1'b0;
				clip_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sep_q[0] <= sep_x;
			sep_q[1] <= sep_y;
			sep_q[2] <= sep_z;
			mi_q[0] <= moment_i_x;
			mi_q[1] <= moment_i_y;
			mi_q[2] <= moment_i_z;
			mj_q[0] <= moment_j_x;
			mj_q[1] <= moment_j_y;
			mj_q[2] <= moment_j_z;
			rsum_q <= radius_sum;
			last_q <= last_neighbour;
			r2_q <= 64'd0;
			mir_q <= '0;
			mjr_q <= '0;
			mumu_q <= '0;
		end
		if (rsp.done) begin
			case (state_q)
				ST_SQUARE: r2_q <= r2_next;
				ST_ROOT: r_q <= rsp.value[31:0];
				ST_UNIT: begin
					u_q[axis_q] <= rsp.value[31:0];
					if (axis_q == 2'd2 && r_q < {1'b0, rsum_q}) r_q <= {1'b0, rsum_q};
				end
				ST_DOT: begin
					case (sub_q)
						2'd0: mir_q <= add_res;
						2'd1: mjr_q <= add_res;
						default: mumu_q <= add_res;
					endcase
				end
				ST_WEIGHT: begin
					if (sub_q == 2'd0) begin
						t_q <= rsp.value;
					end else begin
						w_q <= add_res;
					end
				end
				ST_TERM: begin
					if (sub_q == 2'd1 || sub_q == 2'd2) begin
						t_q <= add_res;
					end else begin
						t_q <= rsp.value;
					end
				end
				ST_SCALE: t_q <= rsp.value;
				default: begin
				end
			endcase
		end
		if (fin_go && last_q) begin
			force_x_q <= sum_q[0];
			force_y_q <= sum_q[1];
			force_z_q <= sum_q[2];
			zero_out_q <= zero_q;
			sat_out_q <= clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign force_x = force_x_q;
	assign force_y = force_y_q;
	assign force_z = force_z_q;
	assign zero_distance_seen = zero_out_q;
	assign saturated = sat_out_q;

endmodule

FILE: rtl/dpfa_checker.sv
// Port-level checks for the dipole pair force accumulator, bound to the top level.
`timescale 1ns / 1ps
module dpfa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [47:0] force_x,
	input logic               saturated,
	input logic               cfg_valid,
	input logic               cfg_ready
);

	// an accepted pair holds off the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// a new result word appears only as a pair finishes
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word without a pair in progress");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(force_x) && $stable(saturated))
		else $error("stalled result word changed");

	// configuration is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind dipole_pair_force_accumulator_top dpfa_checker u_dpfa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.force_x(force_x),
	.saturated(saturated),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
